FILE: rtl/point_rotate_about_axis_core_assert.svh
// assertion macros used by the port-level checker of the rotation core
`ifndef POINT_ROTATE_ABOUT_AXIS_CORE_ASSERT_SVH
`define POINT_ROTATE_ABOUT_AXIS_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PROT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PROT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/prot_pkg.sv
// shared types, constants and the arctangent table of the rotation core
package prot_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned AngW      = 16;
  localparam int unsigned OffW      = CoordW + 1;
  localparam int unsigned GuardBits = 24;
  localparam int unsigned GainShift = 31 - GuardBits;
  localparam int unsigned WorkW     = 60;
  localparam int unsigned ZW        = 33;
  localparam int unsigned RndW      = WorkW - GuardBits;
  localparam int unsigned InW       = 4 * CoordW + AngW;
  localparam int unsigned OutW      = 2 * CoordW;
  localparam int unsigned MaxStages = 30;
  localparam int unsigned DefStages = 16;

  localparam logic signed [CoordW-1:0] GainQ31 = 32'sd1304065748;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } prot_quad_e;

  // one beat of work as it moves down the cell chain
  typedef struct packed {
    logic signed [WorkW-1:0]  x;
    logic signed [WorkW-1:0]  y;
    logic signed [ZW-1:0]     z;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } prot_work_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ZW-1:0] atan_turn(input int unsigned idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = 33'sd536870912;
      1:       v = 33'sd316933406;
      2:       v = 33'sd167458907;
      3:       v = 33'sd85004756;
      4:       v = 33'sd42667331;
      5:       v = 33'sd21354465;
      6:       v = 33'sd10679838;
      7:       v = 33'sd5340245;
      8:       v = 33'sd2670163;
      9:       v = 33'sd1335087;
      10:      v = 33'sd667544;
      11:      v = 33'sd333772;
      12:      v = 33'sd166886;
      13:      v = 33'sd83443;
      14:      v = 33'sd41722;
      15:      v = 33'sd20861;
      16:      v = 33'sd10430;
      17:      v = 33'sd5215;
      18:      v = 33'sd2608;
      19:      v = 33'sd1304;
      20:      v = 33'sd652;
      21:      v = 33'sd326;
      22:      v = 33'sd163;
      23:      v = 33'sd81;
      24:      v = 33'sd41;
      25:      v = 33'sd20;
      26:      v = 33'sd10;
      27:      v = 33'sd5;
      28:      v = 33'sd3;
      29:      v = 33'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/prot_prep.sv
// front end: offset from pivot, quarter turn, gain multiply
module prot_prep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [prot_pkg::InW-1:0]      data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output prot_pkg::prot_work_t          work_o
);
  import prot_pkg::*;

  logic signed [CoordW-1:0] px, py, cx, cy;
  logic [AngW-1:0]          ang;
  logic [AngW:0]            ang_sum;
  prot_quad_e               quad;
  logic [AngW-1:0]          resid;
  logic signed [OffW-1:0]   dx_d, dy_d;
  logic signed [ZW-1:0]     z_d;

  // stage a: offsets, quarter turn already applied
  logic                     va_q;
  logic signed [OffW-1:0]   dx_q, dy_q;
  logic signed [ZW-1:0]     za_q;
  logic signed [CoordW-1:0] cxa_q, cya_q;
  logic                     ready_a;

  // stage b: gain-scaled working values
  logic                     vb_q;
  prot_work_t               wb_q, wb_d;
  logic signed [OffW+CoordW-1:0] prod_x, prod_y;

  assign px  = data_i[CoordW-1:0];
  assign py  = data_i[2*CoordW-1:CoordW];
  assign cx  = data_i[3*CoordW-1:2*CoordW];
  assign cy  = data_i[4*CoordW-1:3*CoordW];
  assign ang = data_i[InW-1:4*CoordW];

  assign ang_sum = {1'b0, ang} + (AngW+1)'(8192);
  assign quad    = prot_quad_e'(ang_sum[AngW-1:AngW-2]);
  assign resid   = ang - {quad, {(AngW-2){1'b0}}};
  assign z_d     = ZW'($signed({resid, 16'h0000}));

  always_comb begin
    case (quad)
      QUAD_1: begin
        dx_d = OffW'(cy) - OffW'(py);
        dy_d = OffW'(px) - OffW'(cx);
      end
      QUAD_2: begin
        dx_d = OffW'(cx) - OffW'(px);
        dy_d = OffW'(cy) - OffW'(py);
      end
      QUAD_3: begin
        dx_d = OffW'(py) - OffW'(cy);
        dy_d = OffW'(cx) - OffW'(px);
      end
      default: begin
        dx_d = OffW'(px) - OffW'(cx);
        dy_d = OffW'(py) - OffW'(cy);
      end
    endcase
  end

  assign ready_o = !va_q || ready_a;
  assign ready_a = !vb_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_o) va_q <= valid_i;
      if (ready_a) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      za_q  <= z_d;
      cxa_q <= cx;
      cya_q <= cy;
    end
  end

  assign prod_x = dx_q * GainQ31;
  assign prod_y = dy_q * GainQ31;

  always_comb begin
    wb_d.x  = WorkW'(prod_x >>> GainShift);
    wb_d.y  = WorkW'(prod_y >>> GainShift);
    wb_d.z  = za_q;
    wb_d.cx = cxa_q;
    wb_d.cy = cya_q;
  end

  always_ff @(posedge clk_i) begin
    if (va_q && ready_a) wb_q <= wb_d;
  end

  assign valid_o = vb_q;
  assign work_o  = wb_q;

endmodule

FILE: rtl/prot_cell.sv
// one cordic micro-rotation cell with its own pipeline register
module prot_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  prot_pkg::prot_work_t work_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output prot_pkg::prot_work_t work_o
);
  import prot_pkg::*;

  localparam logic signed [ZW-1:0] Atan = atan_turn(STAGE);

  logic       v_q;
  prot_work_t w_q, w_d;
  logic signed [WorkW-1:0] xs, ys;

  assign xs = work_i.x >>> STAGE;
  assign ys = work_i.y >>> STAGE;

  always_comb begin
    w_d = work_i;
    if (!work_i.z[ZW-1]) begin
      w_d.x = work_i.x - ys;
      w_d.y = work_i.y + xs;
      w_d.z = work_i.z - Atan;
    end else begin
      w_d.x = work_i.x + ys;
      w_d.y = work_i.y - xs;
      w_d.z = work_i.z + Atan;
    end
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) w_q <= w_d;
  end

  assign valid_o = v_q;
  assign work_o  = w_q;

endmodule

FILE: rtl/prot_post.sv
// back end: rounding, pivot add-back, saturation, output register
module prot_post (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  prot_pkg::prot_work_t      work_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [prot_pkg::OutW-1:0] data_o
);
  import prot_pkg::*;

  localparam int unsigned SumW = RndW + 1;
  localparam logic signed [WorkW-1:0] Half = WorkW'(1) << (GuardBits - 1);
  localparam logic [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  // rounding stage
  logic                     vr_q;
  logic signed [RndW-1:0]   rx_q, ry_q;
  logic signed [CoordW-1:0] cx_q, cy_q;
  logic signed [WorkW-1:0]  rnd_x, rnd_y;
  logic                     ready_r;

  // output stage
  logic                     vo_q;
  logic [OutW-1:0]          out_q;
  logic signed [SumW-1:0]   sum_x, sum_y;
  logic [CoordW-1:0]        sat_x, sat_y;

  assign rnd_x = work_i.x + Half;
  assign rnd_y = work_i.y + Half;

  assign ready_o = !vr_q || ready_r;
  assign ready_r = !vo_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ready_o) vr_q <= valid_i;
      if (ready_r) vo_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rx_q <= rnd_x[WorkW-1:GuardBits];
      ry_q <= rnd_y[WorkW-1:GuardBits];
      cx_q <= work_i.cx;
      cy_q <= work_i.cy;
    end
  end

  assign sum_x = SumW'(rx_q) + SumW'(cx_q);
  assign sum_y = SumW'(ry_q) + SumW'(cy_q);

  // in range when all bits above the coordinate sign agree with it
  always_comb begin
    if ((&sum_x[SumW-1:CoordW-1]) || !(|sum_x[SumW-1:CoordW-1])) begin
      sat_x = sum_x[CoordW-1:0];
    end else begin
      sat_x = sum_x[SumW-1] ? CoordMin : CoordMax;
    end
    if ((&sum_y[SumW-1:CoordW-1]) || !(|sum_y[SumW-1:CoordW-1])) begin
      sat_y = sum_y[CoordW-1:0];
    end else begin
      sat_y = sum_y[SumW-1] ? CoordMin : CoordMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vr_q && ready_r) out_q <= {sat_y, sat_x};
  end

  assign valid_o = vo_q;
  assign data_o  = out_q;

endmodule

FILE: rtl/point_rotate_about_axis_core.sv
// top level of the pipelined cordic point rotation core
//
//  channel  dir  tdata fields (lsb up)                            tuser
//  s_axis   in   point_x, point_y, pivot_x, pivot_y, turn_angle    -
//  m_axis   out  rotated_x, rotated_y                              -
//
// one beat accepted per cycle unless a stall from m_axis has filled the chain; stages:
// two front-end stages (offset and quarter turn, gain multiply), one cell per
// micro-rotation, then rounding and the saturating output register
// every stage has its own valid bit, so bubbles collapse during a stall and
// s_axis keeps taking beats until the whole chain is full
// reset clears only the valid bits; the data registers are not reset
module point_rotate_about_axis_core #(
  parameter int unsigned CORDIC_STAGES = prot_pkg::DefStages
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // point_x, point_y, pivot_x, pivot_y, turn_angle
  input  logic [prot_pkg::InW-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // rotated_x, rotated_y
  output logic [prot_pkg::OutW-1:0] m_axis_tdata
);
  import prot_pkg::*;

  // stage counts past the table length act as the full table
  localparam int unsigned NumCells =
    (CORDIC_STAGES > MaxStages) ? MaxStages : CORDIC_STAGES;

  // link k feeds cell k; link NumCells feeds the back end
  prot_work_t link_work  [NumCells+1];
  logic       link_valid [NumCells+1];
  logic       link_ready [NumCells+1];

  // offset, exact quarter turn and gain compensation
  prot_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .valid_o (link_valid[0]),
    .ready_i (link_ready[0]),
    .work_o  (link_work[0])
  );

  // row of micro-rotation cells, one shift amount each
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    prot_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[g]),
      .ready_o (link_ready[g]),
      .work_i  (link_work[g]),
      .valid_o (link_valid[g+1]),
      .ready_i (link_ready[g+1]),
      .work_o  (link_work[g+1])
    );
  end

  // round off guard bits, add pivot back, saturate
  prot_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (link_valid[NumCells]),
    .ready_o (link_ready[NumCells]),
    .work_i  (link_work[NumCells]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule

FILE: rtl/prot_checker.sv
// port-level checks of the rotation core and their bind
`include "point_rotate_about_axis_core_assert.svh"

module prot_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [prot_pkg::InW-1:0]  s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [prot_pkg::OutW-1:0] m_axis_tdata
);
  import prot_pkg::*;

  logic in_seen;
  assign in_seen = s_axis_tvalid || (|s_axis_tdata);

  // a stalled result beat stays put
  `PROT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "out beat dropped")
  `PROT_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "out beat changed")

  // an empty output register lets the whole chain move
  `PROT_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input blocked with output empty")

  // a draining sink never back-pressures the source
  `PROT_ASSERT_NOW(a_flow_ready, m_axis_tready && (in_seen || !in_seen), s_axis_tready, "input blocked while sink ready")

endmodule

bind point_rotate_about_axis_core prot_checker u_prot_checker (.*);

FILE: tb/point_rotate_about_axis_core_checker.sv
// checker for the rotation core: predicts each result from the input beats and compares
`timescale 1ns / 100ps

module point_rotate_about_axis_core_checker #(
  parameter int unsigned STAGES = prot_pkg::DefStages
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  // point_x, point_y, pivot_x, pivot_y, turn_angle
  input  logic [prot_pkg::InW-1:0]  s_axis_tdata,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // rotated_x, rotated_y
  input  logic [prot_pkg::OutW-1:0] m_axis_tdata,
  output int                        mismatch_cnt_o,
  output int                        pending_cnt_o
);
  import prot_pkg::*;

  // fields listed msb first, so point_x lands in the low bits of tdata
  typedef struct packed {
    logic [AngW-1:0]          turn_angle;
    logic signed [CoordW-1:0] pivot_y;
    logic signed [CoordW-1:0] pivot_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_x;
  } rot_req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] rotated_y;
    logic signed [CoordW-1:0] rotated_x;
  } rot_res_t;

  localparam longint GAIN       = 64'sd1304065748;
  localparam int     GAIN_SHR   = 7;
  localparam int     FRAC_DROP  = 24;
  localparam longint HALF_LSB   = 64'sd8388608;
  localparam longint COORD_MAX  = 64'sd2147483647;
  localparam longint COORD_MIN  = -64'sd2147483648;
  localparam int     TBL_LEN    = 30;
  localparam int     USED_STAGES = (STAGES > TBL_LEN) ? TBL_LEN : STAGES;

  // atan(2^-i) in units of 2^-32 turn
  localparam longint ATAN_STEP [TBL_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1
  };

  rot_res_t rotated_q [$];
  int       mismatch_total = 0;
  int       pending_total  = 0;

  assign mismatch_cnt_o = mismatch_total;
  assign pending_cnt_o  = pending_total;

  function automatic logic [CoordW-1:0] clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX[CoordW-1:0];
    if (v < COORD_MIN) return COORD_MIN[CoordW-1:0];
    return v[CoordW-1:0];
  endfunction

  function automatic rot_res_t rotate_about_pivot(input rot_req_t req);
    longint     dx, dy, swap, x, y, z, nx, ny;
    logic [AngW-1:0] ang_bias, resid;
    prot_quad_e quad;
    rot_res_t   res;
    dx = longint'($signed(req.point_x)) - longint'($signed(req.pivot_x));
    dy = longint'($signed(req.point_y)) - longint'($signed(req.pivot_y));
    // nearest quarter turn, residual wrapped to -1/8..+1/8 turn
    ang_bias = req.turn_angle + 16'd8192;
    quad     = prot_quad_e'(ang_bias[15:14]);
    resid    = req.turn_angle - {quad, 14'd0} + 16'd8192;
    case (quad)
      QUAD_1: begin
        swap = dx; dx = -dy; dy = swap;
      end
      QUAD_2: begin
        dx = -dx; dy = -dy;
      end
      QUAD_3: begin
        swap = dx; dx = dy; dy = -swap;
      end
      default: ;
    endcase
    x = (dx * GAIN) >>> GAIN_SHR;
    y = (dy * GAIN) >>> GAIN_SHR;
    z = (longint'(resid) - 64'sd8192) * 64'sd65536;
    for (int i = 0; i < USED_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + ATAN_STEP[i];
      end
      x = nx;
      y = ny;
    end
    x = (x + HALF_LSB) >>> FRAC_DROP;
    y = (y + HALF_LSB) >>> FRAC_DROP;
    res.rotated_x = clamp_coord(longint'($signed(req.pivot_x)) + x);
    res.rotated_y = clamp_coord(longint'($signed(req.pivot_y)) + y);
    return res;
  endfunction

  always @(posedge clk_i) begin : watch_beats
    rot_res_t want;
    rot_res_t got;
    int       bad;
    bad = 0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        rotated_q.push_back(rotate_about_pivot(rot_req_t'(s_axis_tdata)));
      if (m_axis_tvalid && m_axis_tready) begin
        got = rot_res_t'(m_axis_tdata);
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected result beat x=%0d y=%0d", $time,
                   got.rotated_x, got.rotated_y);
          bad = 1;
        end else begin
          want = rotated_q.pop_front();
          if (got.rotated_x !== want.rotated_x) begin
            $display("%0t: rotated_x expected %0d actual %0d", $time,
                     want.rotated_x, got.rotated_x);
            bad++;
          end
          if (got.rotated_y !== want.rotated_y) begin
            $display("%0t: rotated_y expected %0d actual %0d", $time,
                     want.rotated_y, got.rotated_y);
            bad++;
          end
        end
      end
    end
    mismatch_total <= mismatch_total + bad;
    pending_total  <= rotated_q.size();
  end

endmodule

FILE: tb/point_rotate_about_axis_core_test.sv
// testbench top for the rotation core: clock, reset, stimulus, ready stalls and verdict
`timescale 1ns / 100ps

module point_rotate_about_axis_core_test;

  import prot_pkg::*;

  localparam int unsigned STAGES      = 16;
  localparam int          LATENCY     = STAGES + 4;
  localparam int          STALL_LIMIT = 2000;
  localparam int          RAND_ITEMS  = 460;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // point_x, point_y, pivot_x, pivot_y, turn_angle
  logic [InW-1:0]   s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // rotated_x, rotated_y
  logic [OutW-1:0]  m_axis_tdata;

  int mismatch_cnt;
  int pending_cnt;
  int send_idle_pct = 23;
  int recv_idle_pct = 63;
  int stall_cycles  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  point_rotate_about_axis_core #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  point_rotate_about_axis_core_checker #(
    .STAGES(STAGES)
  ) rotation_check (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .mismatch_cnt_o(mismatch_cnt),
    .pending_cnt_o(pending_cnt)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // cycles since the last beat on either channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    do @(posedge clk_i); while (stall_cycles < STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // one input beat, with random idle cycles in front of it
  task automatic send_point(input logic [CoordW-1:0] ptx, input logic [CoordW-1:0] pty,
                            input logic [CoordW-1:0] pvx, input logic [CoordW-1:0] pvy,
                            input logic [AngW-1:0] ang);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ang, pvy, pvx, pty, ptx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending until every predicted result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  function automatic logic [CoordW-1:0] edge_coord();
    case ($urandom_range(4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    logic [CoordW-1:0] ptx, pty, pvx, pvy;
    logic [AngW-1:0]   ang;
    int                offs_x, offs_y;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: quadrant boundaries, residual extremes, origin pivot
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd0);
    send_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd0);
    send_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd16384);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 16'd8191);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 16'd8192);
    send_point(32'hFFFE_0000, 32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 16'd32768);
    send_point(32'h0005_8000, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 16'd49152);
    send_point(32'h0005_8000, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 16'd57344);
    send_point(32'h0005_8000, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 16'd65535);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 16'd1);
    // offsets that need 33 bits, results that saturate
    send_point(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 16'd0);
    send_point(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 16'd32768);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd32768);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'd16384);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 16'd8192);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 16'd24576);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd12345);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd40960);
    send_point(32'h0012_3456, 32'hFFED_CBA9, 32'h0010_0000, 32'hFFF0_0000, 16'd24575);
    send_point(32'h0012_3456, 32'hFFED_CBA9, 32'h0010_0000, 32'hFFF0_0000, 16'd40961);

    // three random phases: sender stalls less, then more, then no stalls at all
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        drain_results();
        send_idle_pct = 63;
        recv_idle_pct = 23;
      end else if (phase == 2) begin
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < RAND_ITEMS; n++) begin
        ptx = $urandom();
        pty = $urandom();
        pvx = $urandom();
        pvy = $urandom();
        ang = AngW'($urandom());
        case ($urandom_range(9))
          3, 4, 5: begin
            // point close to the pivot, no saturation
            offs_x = $urandom_range(1 << 25) - (1 << 24);
            offs_y = $urandom_range(1 << 25) - (1 << 24);
            pvx = $signed(pvx) >>> 2;
            pvy = $signed(pvy) >>> 2;
            ptx = pvx + offs_x;
            pty = pvy + offs_y;
          end
          6: begin
            pvx = '0;
            pvy = '0;
          end
          7: begin
            // angle right at an octant boundary
            ang = 16'($urandom_range(7) * 8192 + $urandom_range(4)) - 16'd2;
          end
          8: begin
            ptx = edge_coord();
            pty = edge_coord();
            pvx = edge_coord();
            pvy = edge_coord();
          end
          9: begin
            ptx = $signed(ptx) >>> 4;
            pty = $signed(pty) >>> 4;
            pvx = $signed(pvx) >>> 4;
            pvy = $signed(pvy) >>> 4;
          end
          default: ;
        endcase
        send_point(ptx, pty, pvx, pvy, ang);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    // let any stray beat out of the chain
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
